FILE: src/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, register indexes and the steering pattern table for the
// line-follow steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_LEFT  = 2'd1,
		TURN_RIGHT = 2'd2
	} turn_t;

	typedef enum logic [2:0] {
		REG_NORMAL_SPEED    = 3'd0,
		REG_DOWNHILL_SPEED  = 3'd1,
		REG_ENTER_THRESHOLD = 3'd2,
		REG_LEVEL_BAND      = 3'd3,
		REG_CONFIRM_COUNT   = 3'd4
	} reg_index_t;

	localparam int unsigned SPEED_W   = 7;
	localparam int unsigned WHEEL_W   = 8;
	localparam int unsigned ACCEL_W   = 16;
	localparam int unsigned BAND_W    = 15;
	localparam int unsigned CONFIRM_W = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned OFFSET_W  = 6;

	localparam logic [SPEED_W-1:0]        NORMAL_SPEED_RST    = 7'd60;
	localparam logic [SPEED_W-1:0]        DOWNHILL_SPEED_RST  = 7'd30;
	localparam logic signed [ACCEL_W-1:0] ENTER_THRESHOLD_RST = -16'sd4000;
	localparam logic [BAND_W-1:0]         LEVEL_BAND_RST      = 15'd3000;
	localparam logic [CONFIRM_W-1:0]      CONFIRM_COUNT_RST   = 2'd3;

	typedef struct packed {
		turn_t                       kind;
		logic signed [OFFSET_W-1:0]  dleft;
		logic signed [OFFSET_W-1:0]  dright;
	} steer_entry_t;

	typedef struct packed {
		turn_t              turn;
		logic               speed_valid;
		logic [WHEEL_W-1:0] left_speed;
		logic [WHEEL_W-1:0] right_speed;
	} steer_res_t;

	function automatic steer_entry_t steer_lookup(input logic [7:0] pattern);
		steer_entry_t e;
		e = '{kind: TURN_NONE, dleft: 6'sd0, dright: 6'sd0};
		case (pattern) inside
			8'hF0, 8'hE0: e.kind = TURN_LEFT;
			8'h0F, 8'h07: e.kind = TURN_RIGHT;
			8'hEF: e.dright = 6'sd5;
			8'hF7: e.dleft = 6'sd5;
			8'hFB, 8'hF3: e.dleft = 6'sd15;
			8'hDF, 8'hCF: e.dright = 6'sd15;
			8'hBF, 8'h9F: begin
				e.dleft  = -6'sd15;
				e.dright = 6'sd20;
			end
			8'hFD, 8'hF9: begin
				e.dleft  = 6'sd20;
				e.dright = -6'sd15;
			end
			8'h7F, 8'h3F: begin
				e.dleft  = -6'sd25;
				e.dright = 6'sd30;
			end
			8'hFC, 8'hFE: begin
				e.dleft  = 6'sd30;
				e.dright = -6'sd25;
			end
			default: e = '{kind: TURN_NONE, dleft: 6'sd0, dright: 6'sd0};
		endcase
		return e;
	endfunction

endpackage

FILE: src/lfs_if.sv
// ----------------------------------------------------------------------------
// lfs_if
// Valid/ready channels for sensor samples and steering results.
// ----------------------------------------------------------------------------
interface lfs_sample_if;
	logic                                valid;
	logic                                ready;
	logic [7:0]                          sensor_pattern;
	logic signed [lfs_pkg::ACCEL_W-1:0]  accel_forward;

	modport source (output valid, output sensor_pattern, output accel_forward,
		input ready);
	modport sink (input valid, input sensor_pattern, input accel_forward,
		output ready);
endinterface

interface lfs_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    turn_command;
	logic                          speed_valid;
	logic [lfs_pkg::WHEEL_W-1:0]   left_speed;
	logic [lfs_pkg::WHEEL_W-1:0]   right_speed;
	logic                          downhill_active;

	modport source (output valid, output turn_command, output speed_valid,
		output left_speed, output right_speed, output downhill_active, input ready);
	modport sink (input valid, input turn_command, input speed_valid,
		input left_speed, input right_speed, input downhill_active, output ready);
endinterface

FILE: src/lfs_steer.sv
// ----------------------------------------------------------------------------
// lfs_steer
// Pattern lookup: turn command or wheel speed pair from a base speed.
// ----------------------------------------------------------------------------
module lfs_steer (
	input  logic [7:0]                    pattern,
	input  logic [lfs_pkg::SPEED_W-1:0]   base,
	output lfs_pkg::steer_res_t           res
);

	lfs_pkg::steer_entry_t entry;
	logic signed [lfs_pkg::WHEEL_W:0] sum_l;
	logic signed [lfs_pkg::WHEEL_W:0] sum_r;

	assign entry = lfs_pkg::steer_lookup(pattern);
	assign sum_l = $signed({2'b00, base}) + (lfs_pkg::WHEEL_W+1)'(entry.dleft);
	assign sum_r = $signed({2'b00, base}) + (lfs_pkg::WHEEL_W+1)'(entry.dright);

	always_comb begin
		if (entry.kind != lfs_pkg::TURN_NONE) begin
			res.turn        = entry.kind;
			res.speed_valid = 1'b0;
			res.left_speed  = '0;
			res.right_speed = '0;
		end else begin
			res.turn        = lfs_pkg::TURN_NONE;
			res.speed_valid = 1'b1;
			// negative sums saturate at zero
			res.left_speed  = sum_l[lfs_pkg::WHEEL_W] ? '0 : sum_l[lfs_pkg::WHEEL_W-1:0];
			res.right_speed = sum_r[lfs_pkg::WHEEL_W] ? '0 : sum_r[lfs_pkg::WHEEL_W-1:0];
		end
	end

endmodule

FILE: src/line_follow_steering_with_slope_mode.sv
// ----------------------------------------------------------------------------
// line_follow_steering_with_slope_mode
// Line-follow steering lookup with a downhill speed mode.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one sensor pattern and one forward acceleration item per
//   control tick; result carries one steering item back for each of them.
//   cfg_we/cfg_index/cfg_data write the five registers (speeds, entry
//   threshold, level band, confirm count); write only while idle.
// Flow: an accepted sample is held in the input register, then moves to the
//   result register when that is free (empty, or its item is being taken).
//   Throughput: one item per cycle while result.ready stays high; the slope
//   qualifier and the pattern lookup lie in the logic between the registers.
// Reset: registers return to their defaults, the mode to following and the
//   run count to zero; both stages come up empty.
// Stall: while result.ready is low a finished item holds in the result
//   register; the input register still takes one more item, then
//   sample.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module line_follow_steering_with_slope_mode (
	input  logic                            clk,
	input  logic                            arst_n,
	lfs_sample_if.sink                      sample,
	lfs_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [lfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfs_pkg::CFG_W-1:0]       cfg_data
);

	logic [lfs_pkg::SPEED_W-1:0]          normal_speed_q;
	logic [lfs_pkg::SPEED_W-1:0]          downhill_speed_q;
	logic signed [lfs_pkg::ACCEL_W-1:0]   enter_threshold_q;
	logic [lfs_pkg::BAND_W-1:0]           level_band_q;
	logic [lfs_pkg::CONFIRM_W-1:0]        confirm_count_q;

	logic                                 downhill_q;
	logic [lfs_pkg::CONFIRM_W-1:0]        run_q;

	logic                                 valid_s1;
	logic [7:0]                           pattern_s1;
	logic signed [lfs_pkg::ACCEL_W-1:0]   accel_s1;

	logic                                 res_valid_q;
	lfs_pkg::steer_res_t                  res_q;
	logic                                 res_downhill_q;

	logic                                 out_free;
	logic                                 adv_s1;
	logic [lfs_pkg::ACCEL_W:0]            mag;
	logic [lfs_pkg::CONFIRM_W-1:0]        need;
	logic [lfs_pkg::CONFIRM_W-1:0]        run_inc;
	logic                                 qualifies;
	logic                                 downhill_next;
	logic [lfs_pkg::CONFIRM_W-1:0]        run_next;
	logic [lfs_pkg::SPEED_W-1:0]          base;
	lfs_pkg::steer_res_t                  steer;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_speed_q    <= lfs_pkg::NORMAL_SPEED_RST;
			downhill_speed_q  <= lfs_pkg::DOWNHILL_SPEED_RST;
			enter_threshold_q <= lfs_pkg::ENTER_THRESHOLD_RST;
			level_band_q      <= lfs_pkg::LEVEL_BAND_RST;
			confirm_count_q   <= lfs_pkg::CONFIRM_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfs_pkg::REG_NORMAL_SPEED:    normal_speed_q <= cfg_data[lfs_pkg::SPEED_W-1:0];
				lfs_pkg::REG_DOWNHILL_SPEED:  downhill_speed_q <= cfg_data[lfs_pkg::SPEED_W-1:0];
				lfs_pkg::REG_ENTER_THRESHOLD: enter_threshold_q <= $signed(cfg_data);
				lfs_pkg::REG_LEVEL_BAND:      level_band_q <= cfg_data[lfs_pkg::BAND_W-1:0];
				lfs_pkg::REG_CONFIRM_COUNT:   confirm_count_q <= cfg_data[lfs_pkg::CONFIRM_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free     = !res_valid_q || result.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	// slope qualifier
	assign mag       = accel_s1[lfs_pkg::ACCEL_W-1]
		? (lfs_pkg::ACCEL_W+1)'(-{accel_s1[lfs_pkg::ACCEL_W-1], accel_s1})
		: {1'b0, accel_s1};
	assign need      = (confirm_count_q == '0) ? lfs_pkg::CONFIRM_W'(1) : confirm_count_q;
	assign run_inc   = run_q + lfs_pkg::CONFIRM_W'(1);
	assign qualifies = downhill_q ? (mag < {2'b00, level_band_q})
		: (accel_s1 < enter_threshold_q);

	always_comb begin
		downhill_next = downhill_q;
		run_next      = '0;
		if (qualifies) begin
			if (run_inc >= need) begin
				downhill_next = !downhill_q;
			end else begin
				run_next = run_inc;
			end
		end
	end

	assign base = downhill_next ? downhill_speed_q : normal_speed_q;

	lfs_steer u_steer (
		.pattern (pattern_s1),
		.base    (base),
		.res     (steer)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			downhill_q  <= 1'b0;
			run_q       <= '0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				downhill_q <= downhill_next;
				run_q      <= run_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			pattern_s1 <= sample.sensor_pattern;
			accel_s1   <= sample.accel_forward;
		end
		if (adv_s1) begin
			res_q          <= steer;
			res_downhill_q <= downhill_next;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.turn_command    = res_q.turn;
	assign result.speed_valid     = res_q.speed_valid;
	assign result.left_speed      = res_q.left_speed;
	assign result.right_speed     = res_q.right_speed;
	assign result.downhill_active = res_downhill_q;

	// a turn item carries no wheel speeds
	a_turn_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.turn != lfs_pkg::TURN_NONE)
		|-> (!res_q.speed_valid && res_q.left_speed == '0 && res_q.right_speed == '0))
		else $error("turn item with speed fields set");

	// mode and run count move only when an item leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(downhill_q) && $stable(run_q)))
		else $error("qualifier state changed without an item");

	// the run count never reaches the switch point
	a_run_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (run_q < $past(need)))
		else $error("run count reached confirm count");

	// an empty input stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample.ready)
		else $error("input stage empty but not ready");

endmodule
